FILE: sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types, constants and tables of the Gregorian date unit
// Operation codes, sequencer states, serial-day bounds and month tables.
// ----------------------------------------------------------------------------
package gda_pkg;

	typedef enum logic [1:0] {
		FN_ADD  = 2'd0,
		FN_SUB  = 2'd1,
		FN_DIFF = 2'd2,
		FN_CMP  = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_YADJ,
		ST_MUL365,
		ST_ACC0,
		ST_ACC1,
		ST_ACC2,
		ST_ACC3,
		ST_ACC4,
		ST_CNT,
		ST_CLO,
		ST_CHI,
		ST_ERA,
		ST_CEN,
		ST_QUAD,
		ST_YRS,
		ST_YMUL,
		ST_YS1,
		ST_YS2,
		ST_MON,
		ST_DAY,
		ST_YFIN,
		ST_DIFF,
		ST_DHI,
		ST_DLO,
		ST_OUT
	} state_t;

	localparam int YEAR_SHIFT = 400;
	localparam int YEAR_MAX   = 9999;
	localparam int MONTH_MAX  = 12;
	localparam int DAY_MAX    = 31;
	localparam int SERIAL_LO  = 146403;   // 0001-01-01
	localparam int SERIAL_HI  = 3798461;  // 9999-12-31
	localparam int DIFF_MAX   = 4194303;
	localparam int ERA_DAYS   = 146097;
	localparam int CENT_DAYS  = 36524;
	localparam int QUAD_DAYS  = 1461;
	localparam int YEAR_DAYS  = 365;
	localparam int RECIP_25   = 5243;     // ceil(2^17 / 25)
	localparam int RECIP_SH   = 17;

	// day of March-based year of the 1st of the month, minus one; month clamped to 1..12
	function automatic logic signed [9:0] month_base(input logic [3:0] m);
		logic signed [9:0] r;
		case (m) inside
			4'd0, 4'd1:   r = 10'sd305;
			4'd2:         r = 10'sd336;
			4'd3:         r = -10'sd1;
			4'd4:         r = 10'sd30;
			4'd5:         r = 10'sd60;
			4'd6:         r = 10'sd91;
			4'd7:         r = 10'sd121;
			4'd8:         r = 10'sd152;
			4'd9:         r = 10'sd183;
			4'd10:        r = 10'sd213;
			4'd11:        r = 10'sd244;
			[4'd12:4'd15]: r = 10'sd274;
			default:      r = 10'sd274;
		endcase
		return r;
	endfunction

	// first day of month index (0 = March) in the March-based year
	function automatic logic [8:0] mar_start(input logic [3:0] idx);
		logic [8:0] r;
		case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd366;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] cent_years(input logic [1:0] c);
		logic [8:0] r;
		case (c)
			2'd0:    r = 9'd0;
			2'd1:    r = 9'd100;
			2'd2:    r = 9'd200;
			default: r = 9'd300;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/gda_if.sv
// ----------------------------------------------------------------------------
// gda_if: request and response channels of the Gregorian date unit
// Valid/ready channels; a request or response moves when both are high.
// ----------------------------------------------------------------------------
interface gda_req_if #(parameter int COUNT_WIDTH = 20);
	logic                   valid;
	logic                   ready;
	logic [1:0]             func;
	logic [13:0]            a_year;
	logic [3:0]             a_month;
	logic [4:0]             a_day;
	logic [13:0]            b_year;
	logic [3:0]             b_month;
	logic [4:0]             b_day;
	logic [COUNT_WIDTH-1:0] day_count;

	modport source (output valid, func, a_year, a_month, a_day, b_year, b_month, b_day,
		day_count, input ready);
	modport sink (input valid, func, a_year, a_month, a_day, b_year, b_month, b_day,
		day_count, output ready);
endinterface

interface gda_rsp_if;
	logic               valid;
	logic               ready;
	logic [13:0]        res_year;
	logic [3:0]         res_month;
	logic [4:0]         res_day;
	logic signed [22:0] day_difference;
	logic               a_less;
	logic               a_equal;
	logic               out_of_range;

	modport source (output valid, res_year, res_month, res_day, day_difference, a_less,
		a_equal, out_of_range, input ready);
	modport sink (input valid, res_year, res_month, res_day, day_difference, a_less,
		a_equal, out_of_range, output ready);
endinterface

FILE: sv/gda_alu.sv
// ----------------------------------------------------------------------------
// gda_alu: shared add/subtract unit of the date sequencer
// Signed sum or difference with a sign flag for compares and trial subtracts.
// ----------------------------------------------------------------------------
module gda_alu #(
	parameter int W = 24
) (
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  logic                sub,
	output logic signed [W-1:0] sum,
	output logic                neg
);
	assign sum = sub ? (a - b) : (a + b);
	assign neg = sum[W-1];
endmodule

FILE: sv/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic: Gregorian date add, subtract, difference, compare
//
//   channel  dir  fields
//   req      in   func, a_year/month/day, b_year/month/day, day_count
//   rsp      out  res_year/month/day, day_difference, a_less, a_equal,
//                 out_of_range
//
// One request at a time; the serial-day arithmetic goes through one shared
// adder and one small multiplier. The month scan sets how long an
// add/subtract request takes, and a saturated date skips the scan; a
// compare goes from idle straight to the output step. The sequencer returns
// to idle before it takes the next request. A held response stalls the
// sequencer only at its last step. Reset clears the sequencer and rsp valid.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic
	import gda_pkg::*;
#(
	parameter int COUNT_WIDTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	gda_req_if.sink     req,
	gda_rsp_if.source   rsp
);
	localparam int AW = (COUNT_WIDTH > 23 ? COUNT_WIDTH : 23) + 2;
	typedef logic signed [AW-1:0] acc_t;

	localparam acc_t LO_C   = acc_t'(SERIAL_LO);
	localparam acc_t HI_C   = acc_t'(SERIAL_HI);
	localparam acc_t DMAX_C = acc_t'(DIFF_MAX);

	state_t state_q, state_d;

	func_t                  func_q;
	logic [13:0]            a_year_q, b_year_q;
	logic [3:0]             a_month_q, b_month_q;
	logic [4:0]             a_day_q, b_day_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   sel_b_q;

	acc_t        acc_q, zs_q;
	logic [14:0] y_q;
	logic [27:0] mul_q;
	logic [2:0]  k_q;
	logic [4:0]  quo_q, quo_next;
	logic [4:0]  era_q, quad_q;
	logic [1:0]  cen_q, yrs_q;
	logic [8:0]  doy_q;
	logic [3:0]  mp_q;

	logic [13:0] ry_q;
	logic [3:0]  rm_q;
	logic [4:0]  rd_q;
	logic        oor_q;

	logic               rsp_valid_q;
	logic [13:0]        rsp_year_q;
	logic [3:0]         rsp_month_q;
	logic [4:0]         rsp_day_q;
	logic signed [22:0] rsp_diff_q;
	logic               rsp_less_q, rsp_equal_q, rsp_oor_q;

	logic [13:0] year_sel;
	logic [3:0]  month_sel;
	logic [4:0]  day_sel;
	logic        early_in;
	logic        early_out;
	logic [10:0] q100;
	logic        out_fire;
	logic        cmp_less, cmp_equal;

	acc_t        alu_a, alu_b, alu_sum;
	logic        alu_sub, alu_neg;
	logic [14:0] mul_a;
	logic [12:0] mul_b;
	logic [27:0] mul_p;

	assign year_sel  = sel_b_q ? b_year_q : a_year_q;
	assign month_sel = sel_b_q ? b_month_q : a_month_q;
	assign day_sel   = sel_b_q ? b_day_q : a_day_q;
	assign early_in  = (month_sel <= 4'd2);
	assign early_out = (mp_q >= 4'd10);
	assign q100      = mul_q[RECIP_SH+10:RECIP_SH];
	assign quo_next  = {quo_q[3:0], ~alu_neg};
	assign out_fire  = (state_q == ST_OUT) && (!rsp_valid_q || rsp.ready);

	assign cmp_equal = (a_year_q == b_year_q) && (a_month_q == b_month_q) &&
		(a_day_q == b_day_q);
	assign cmp_less  = (a_year_q < b_year_q) ||
		((a_year_q == b_year_q) && (a_month_q < b_month_q)) ||
		((a_year_q == b_year_q) && (a_month_q == b_month_q) && (a_day_q < b_day_q));

	gda_alu #(.W(AW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.sum (alu_sum),
		.neg (alu_neg)
	);

	assign mul_p = {13'd0, mul_a} * {15'd0, mul_b};

	// operand select
	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		mul_a   = y_q;
		mul_b   = 13'(YEAR_DAYS);
		case (state_q)
			ST_YADJ: begin
				alu_a = acc_t'(year_sel);
				alu_b = early_in ? acc_t'(YEAR_SHIFT - 1) : acc_t'(YEAR_SHIFT);
			end
			ST_ACC0: begin
				alu_a = acc_t'(mul_q);
				alu_b = acc_t'(y_q[14:2]);
				mul_a = {2'd0, y_q[14:2]};
				mul_b = 13'(RECIP_25);
			end
			ST_ACC1: begin
				alu_b   = acc_t'(q100);
				alu_sub = 1'b1;
			end
			ST_ACC2: alu_b = acc_t'(q100[10:2]);
			ST_ACC3: alu_b = acc_t'(month_base(month_sel));
			ST_ACC4: alu_b = acc_t'(day_sel);
			ST_CNT: begin
				alu_b   = acc_t'(cnt_q);
				alu_sub = (func_q == FN_SUB);
			end
			ST_CLO: begin
				alu_b   = LO_C;
				alu_sub = 1'b1;
			end
			ST_CHI: begin
				alu_a   = HI_C;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_ERA: begin
				alu_b   = acc_t'(ERA_DAYS) << k_q;
				alu_sub = 1'b1;
			end
			ST_CEN: begin
				alu_b   = acc_t'(CENT_DAYS) << k_q;
				alu_sub = 1'b1;
			end
			ST_QUAD: begin
				alu_b   = acc_t'(QUAD_DAYS) << k_q;
				alu_sub = 1'b1;
			end
			ST_YRS: begin
				alu_b   = acc_t'(YEAR_DAYS) << k_q;
				alu_sub = 1'b1;
			end
			ST_YMUL: begin
				mul_a = 15'(era_q);
				mul_b = 13'(YEAR_SHIFT);
			end
			ST_YS1: begin
				alu_a = acc_t'(mul_q);
				alu_b = acc_t'(cent_years(cen_q));
			end
			ST_YS2: alu_b = acc_t'({quad_q, yrs_q});
			ST_MON: begin
				alu_a   = acc_t'(doy_q);
				alu_b   = acc_t'(mar_start(mp_q + 4'd1));
				alu_sub = 1'b1;
			end
			ST_DAY: begin
				alu_a   = acc_t'(doy_q + 9'd1);
				alu_b   = acc_t'(mar_start(mp_q));
				alu_sub = 1'b1;
			end
			ST_YFIN: alu_b = early_out ? acc_t'(1 - YEAR_SHIFT) : acc_t'(-YEAR_SHIFT);
			ST_DIFF: begin
				alu_a   = zs_q;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_DHI: begin
				alu_a   = DMAX_C;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_DLO: alu_b = DMAX_C;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (func_t'(req.func) == FN_CMP) ? ST_OUT : ST_YADJ;
				end
			end
			ST_YADJ:   state_d = ST_MUL365;
			ST_MUL365: state_d = ST_ACC0;
			ST_ACC0:   state_d = ST_ACC1;
			ST_ACC1:   state_d = ST_ACC2;
			ST_ACC2:   state_d = ST_ACC3;
			ST_ACC3:   state_d = ST_ACC4;
			ST_ACC4: begin
				if (func_q == FN_DIFF) begin
					state_d = sel_b_q ? ST_DIFF : ST_YADJ;
				end else begin
					state_d = ST_CNT;
				end
			end
			ST_CNT:  state_d = ST_CLO;
			ST_CLO:  state_d = alu_neg ? ST_OUT : ST_CHI;
			ST_CHI:  state_d = alu_neg ? ST_OUT : ST_ERA;
			ST_ERA:  if (k_q == 3'd0) state_d = ST_CEN;
			ST_CEN:  if (k_q == 3'd0) state_d = ST_QUAD;
			ST_QUAD: if (k_q == 3'd0) state_d = ST_YRS;
			ST_YRS:  if (k_q == 3'd0) state_d = ST_YMUL;
			ST_YMUL: state_d = ST_YS1;
			ST_YS1:  state_d = ST_YS2;
			ST_YS2:  state_d = ST_MON;
			ST_MON:  if (alu_neg) state_d = ST_DAY;
			ST_DAY:  state_d = ST_YFIN;
			ST_YFIN: state_d = ST_OUT;
			ST_DIFF: state_d = ST_DHI;
			ST_DHI:  state_d = ST_DLO;
			ST_DLO:  state_d = ST_OUT;
			ST_OUT:  if (out_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					func_q    <= func_t'(req.func);
					a_year_q  <= req.a_year;
					a_month_q <= req.a_month;
					a_day_q   <= req.a_day;
					b_year_q  <= req.b_year;
					b_month_q <= req.b_month;
					b_day_q   <= req.b_day;
					cnt_q     <= COUNT_WIDTH'(req.day_count);
					sel_b_q   <= 1'b0;
					oor_q     <= 1'b0;
				end
			end
			ST_YADJ:   y_q <= alu_sum[14:0];
			ST_MUL365: mul_q <= mul_p;
			ST_ACC0: begin
				acc_q <= alu_sum;
				mul_q <= mul_p;
			end
			ST_ACC1, ST_ACC2, ST_ACC3, ST_CNT, ST_YS1, ST_DIFF: acc_q <= alu_sum;
			ST_ACC4: begin
				if (func_q == FN_DIFF && !sel_b_q) begin
					zs_q    <= alu_sum;
					sel_b_q <= 1'b1;
				end else begin
					acc_q <= alu_sum;
				end
			end
			ST_CLO: begin
				if (alu_neg) begin
					ry_q  <= 14'd1;
					rm_q  <= 4'd1;
					rd_q  <= 5'd1;
					oor_q <= 1'b1;
				end
			end
			ST_CHI: begin
				if (alu_neg) begin
					ry_q  <= 14'(YEAR_MAX);
					rm_q  <= 4'(MONTH_MAX);
					rd_q  <= 5'(DAY_MAX);
					oor_q <= 1'b1;
				end
				k_q   <= 3'd4;
				quo_q <= '0;
			end
			ST_ERA, ST_CEN, ST_QUAD, ST_YRS: begin
				if (!alu_neg) acc_q <= alu_sum;
				if (k_q != 3'd0) begin
					quo_q <= quo_next;
					k_q   <= k_q - 3'd1;
				end else begin
					quo_q <= '0;
					case (state_q)
						ST_ERA: begin
							era_q <= quo_next;
							k_q   <= 3'd1;
						end
						ST_CEN: begin
							cen_q <= quo_next[1:0];
							k_q   <= 3'd4;
						end
						ST_QUAD: begin
							quad_q <= quo_next;
							k_q    <= 3'd1;
						end
						default: yrs_q <= quo_next[1:0];
					endcase
				end
			end
			ST_YMUL: begin
				mul_q <= mul_p;
				doy_q <= acc_q[8:0];
			end
			ST_YS2: begin
				acc_q <= alu_sum;
				mp_q  <= '0;
			end
			ST_MON: if (!alu_neg) mp_q <= mp_q + 4'd1;
			ST_DAY: begin
				rd_q <= alu_sum[4:0];
				rm_q <= (mp_q < 4'd10) ? (mp_q + 4'd3) : (mp_q - 4'd9);
			end
			ST_YFIN: ry_q <= alu_sum[13:0];
			ST_DHI: begin
				if (alu_neg) begin
					acc_q <= DMAX_C;
					oor_q <= 1'b1;
				end
			end
			ST_DLO: begin
				if (alu_neg) begin
					acc_q <= -DMAX_C;
					oor_q <= 1'b1;
				end
			end
			ST_OUT: begin
				if (out_fire) begin
					case (func_q)
						FN_ADD, FN_SUB: begin
							rsp_year_q  <= ry_q;
							rsp_month_q <= rm_q;
							rsp_day_q   <= rd_q;
							rsp_diff_q  <= '0;
							rsp_less_q  <= 1'b0;
							rsp_equal_q <= 1'b0;
							rsp_oor_q   <= oor_q;
						end
						FN_DIFF: begin
							rsp_year_q  <= '0;
							rsp_month_q <= '0;
							rsp_day_q   <= '0;
							rsp_diff_q  <= acc_q[22:0];
							rsp_less_q  <= 1'b0;
							rsp_equal_q <= 1'b0;
							rsp_oor_q   <= oor_q;
						end
						default: begin
							rsp_year_q  <= '0;
							rsp_month_q <= '0;
							rsp_day_q   <= '0;
							rsp_diff_q  <= '0;
							rsp_less_q  <= cmp_less;
							rsp_equal_q <= cmp_equal;
							rsp_oor_q   <= 1'b0;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= (rsp_valid_q && !rsp.ready) || out_fire;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.res_year       = rsp_year_q;
	assign rsp.res_month      = rsp_month_q;
	assign rsp.res_day        = rsp_day_q;
	assign rsp.day_difference = rsp_diff_q;
	assign rsp.a_less         = rsp_less_q;
	assign rsp.a_equal        = rsp_equal_q;
	assign rsp.out_of_range   = rsp_oor_q;

endmodule

FILE: sv/gda_checker.sv
// ----------------------------------------------------------------------------
// gda_checker: port-level checks of the Gregorian date unit
// Bound to the top level; watches the request and response channels.
// ----------------------------------------------------------------------------
module gda_checker
	import gda_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [13:0]        res_year,
	input logic [3:0]         res_month,
	input logic [4:0]         res_day,
	input logic signed [22:0] day_difference,
	input logic               a_less,
	input logic               a_equal,
	input logic               out_of_range
);
	// one request in flight
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_year) && $stable(res_month) &&
		$stable(res_day) && $stable(day_difference) && $stable(out_of_range))
		else $error("stalled response changed");

	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (a_less || a_equal) |->
		!(a_less && a_equal) && res_year == 14'd0 && day_difference == 23'sd0 &&
		!out_of_range)
		else $error("compare response inconsistent");

	a_sat_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_of_range && res_year != 14'd0 |->
		(res_year == 14'd1 && res_month == 4'd1 && res_day == 5'd1) ||
		(res_year == 14'(YEAR_MAX) && res_month == 4'(MONTH_MAX) &&
		res_day == 5'(DAY_MAX)))
		else $error("out-of-range date not saturated");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.res_year       (rsp.res_year),
	.res_month      (rsp.res_month),
	.res_day        (rsp.res_day),
	.day_difference (rsp.day_difference),
	.a_less         (rsp.a_less),
	.a_equal        (rsp.a_equal),
	.out_of_range   (rsp.out_of_range)
);
